// ----- hw/rtl/dpmbc_pkg.sv -----
// ----------------------------------------------------------------------------
// dpmbc_pkg
// Shared types and constants of the dual port memory bus controller.
// ----------------------------------------------------------------------------
package dpmbc_pkg;

    localparam int DATA_W    = 32;
    localparam int BE_W      = 4;
    // word count of the local memory; must be a power of two
    localparam int MEM_WORDS = 16384;
    localparam int MEM_IDX_W = $clog2(MEM_WORDS);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_BASE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = CFG_IDX_W'(1);

    localparam logic [DATA_W-1:0] START_ADDRESS_RST = 32'h1000_0000;
    localparam logic [DATA_W-1:0] WINDOW_LIMIT_RST  = 32'h101F_FFFF;
    localparam logic [BE_W-1:0]   BUS_SEL_ALL       = 4'hF;

    typedef struct packed {
        logic              instr_strobe;
        logic [DATA_W-1:0] instr_address;
        logic              data_strobe;
        logic              data_write;
        logic [DATA_W-1:0] data_address;
        logic [DATA_W-1:0] data_write_value;
        logic [BE_W-1:0]   byte_enables;
        logic              bus_ack_in;
        logic [DATA_W-1:0] bus_read_value;
    } dpmbc_in_t;

    typedef struct packed {
        logic              instr_ack;
        logic [DATA_W-1:0] instr_read_value;
        logic              data_ack;
        logic [DATA_W-1:0] data_read_value;
        logic [DATA_W-1:0] bus_address;
        logic [DATA_W-1:0] bus_write_value;
        logic              bus_cycle_strobe;
        logic              bus_write_enable;
        logic [BE_W-1:0]   bus_select;
    } dpmbc_out_t;

    // memory access issued by the sequencer
    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [MEM_IDX_W-1:0] index;
        logic [DATA_W-1:0]    wdata;
        logic [DATA_W-1:0]    wmask;
    } dpmbc_mem_req_t;

endpackage

// ----- hw/rtl/dpmbc_ram.sv -----
// ----------------------------------------------------------------------------
// dpmbc_ram
// Generic simple dual port RAM, bit write mask, registered read.
// ----------------------------------------------------------------------------
module dpmbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [WIDTH-1:0]         wr_mask,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int i = 0; i < WIDTH; i++) begin
                if (wr_mask[i]) begin
                    mem[wr_addr][i] <= wr_data[i];
                end
            end
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/dpmbc_fsm.sv -----
// ----------------------------------------------------------------------------
// dpmbc_fsm
// Phase sequencer: decodes each tick request, holds the window registers,
// drives the memory port and forms the result word.
// ----------------------------------------------------------------------------
module dpmbc_fsm (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  dpmbc_pkg::dpmbc_in_t            item,
    input  logic [dpmbc_pkg::DATA_W-1:0]    rd_word,
    input  logic                            cfg_write,
    input  logic [dpmbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dpmbc_pkg::DATA_W-1:0]    cfg_data,
    output dpmbc_pkg::dpmbc_out_t           result,
    output dpmbc_pkg::dpmbc_mem_req_t       mem_req
);
    import dpmbc_pkg::*;

    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_IDLE = 4'd0;
    localparam logic [PH_W-1:0] PH_DR1  = 4'd1;
    localparam logic [PH_W-1:0] PH_DR2  = 4'd2;
    localparam logic [PH_W-1:0] PH_DW1  = 4'd3;
    localparam logic [PH_W-1:0] PH_DW2  = 4'd4;
    localparam logic [PH_W-1:0] PH_IR1  = 4'd5;
    localparam logic [PH_W-1:0] PH_IR2  = 4'd6;
    localparam logic [PH_W-1:0] PH_WW1  = 4'd7;
    localparam logic [PH_W-1:0] PH_WW2  = 4'd8;
    localparam logic [PH_W-1:0] PH_WW3  = 4'd9;
    localparam logic [PH_W-1:0] PH_WR1  = 4'd10;
    localparam logic [PH_W-1:0] PH_WR2  = 4'd11;

    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [DATA_W-1:0] start_address_reg;
    logic [DATA_W-1:0] window_limit_reg;
    logic [DATA_W-1:0] offset;
    logic              local_hit;
    logic [DATA_W-1:0] byte_mask;
    logic              rd_en, wr_en;
    logic [MEM_IDX_W-1:0] rd_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            start_address_reg <= START_ADDRESS_RST;
            window_limit_reg  <= WINDOW_LIMIT_RST;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
            end
            if (cfg_write) begin
                unique case (cfg_index)
                    CFG_WIN_BASE:     start_address_reg <= cfg_data;
                    CFG_WINDOW_LIMIT: window_limit_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // unsigned wrap compare of the offset into the local window
    assign offset    = item.data_address - start_address_reg;
    assign local_hit = (offset <= window_limit_reg);

    always_comb begin
        for (int k = 0; k < BE_W; k++) begin
            byte_mask[8*k +: 8] = {8{item.byte_enables[k]}};
        end
    end

    always_comb begin
        result     = '0;
        phase_next = phase_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        rd_index   = item.data_address[MEM_IDX_W+1:2];
        unique case (phase_reg)
            PH_IDLE: begin
                if (item.instr_strobe) begin
                    phase_next = PH_IR1;
                end else if (item.data_strobe) begin
                    if (local_hit) begin
                        phase_next = item.data_write ? PH_DW1 : PH_DR1;
                    end else begin
                        phase_next = item.data_write ? PH_WW1 : PH_WR1;
                    end
                end
            end
            PH_DR1: begin
                rd_en      = 1'b1;
                phase_next = PH_DR2;
            end
            PH_DR2: begin
                result.data_ack        = 1'b1;
                result.data_read_value = rd_word;
                phase_next             = PH_IDLE;
            end
            PH_DW1: begin
                wr_en      = 1'b1;
                phase_next = PH_DW2;
            end
            PH_DW2: begin
                result.data_ack = 1'b1;
                phase_next      = PH_IDLE;
            end
            PH_IR1: begin
                rd_en      = 1'b1;
                rd_index   = item.instr_address[MEM_IDX_W+1:2];
                phase_next = PH_IR2;
            end
            PH_IR2: begin
                result.instr_ack        = 1'b1;
                result.instr_read_value = rd_word;
                phase_next              = PH_IDLE;
            end
            PH_WW1, PH_WW2, PH_WW3: begin
                result.bus_address      = item.data_address;
                result.bus_write_value  = item.data_write_value;
                result.bus_cycle_strobe = 1'b1;
                result.bus_write_enable = 1'b1;
                result.bus_select       = BUS_SEL_ALL;
                if (phase_reg == PH_WW1) begin
                    phase_next = PH_WW2;
                end else if (phase_reg == PH_WW2) begin
                    phase_next = item.bus_ack_in ? PH_WW3 : PH_WW2;
                end else begin
                    result.data_ack = 1'b1;
                    phase_next      = PH_IDLE;
                end
            end
            PH_WR1: begin
                result.bus_address      = item.data_address;
                result.bus_cycle_strobe = 1'b1;
                result.bus_select       = BUS_SEL_ALL;
                if (item.bus_ack_in) begin
                    phase_next = PH_WR2;
                end
            end
            PH_WR2: begin
                result.bus_address      = item.data_address;
                result.bus_cycle_strobe = 1'b1;
                result.bus_select       = BUS_SEL_ALL;
                result.data_ack         = 1'b1;
                result.data_read_value  = item.bus_read_value;
                phase_next              = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // memory is touched only by an accepted request
    assign mem_req.rd_en = rd_en & accept;
    assign mem_req.wr_en = wr_en & accept;
    assign mem_req.index = rd_index;
    assign mem_req.wdata = item.data_write_value;
    assign mem_req.wmask = byte_mask;

    a_wr_only_dw1: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (accept && phase_reg == PH_DW1))
        else $error("memory write outside local write phase");

    a_read_then_return: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (phase_reg == PH_DR1 || phase_reg == PH_IR1)) |=>
        (phase_reg == PH_DR2 || phase_reg == PH_IR2))
        else $error("local read not followed by return phase");

    a_one_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        !(result.instr_ack && result.data_ack))
        else $error("instruction and data ack together");

    a_bus_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !result.bus_cycle_strobe |-> (result.bus_select == '0 && !result.bus_write_enable))
        else $error("bus signals active without a cycle");

endmodule

// ----- hw/rtl/dual_port_memory_bus_controller.sv -----
// ----------------------------------------------------------------------------
// dual_port_memory_bus_controller
// Instruction/data port controller: local word memory plus wishbone forwarding.
// ----------------------------------------------------------------------------
// Each request's result is registered and offered in the cycle after the
//   request is accepted.
// Throughput: one request per cycle while the receiver takes results; a local
//   read's word comes from the RAM register and is returned with the following request.
// Reset: synchronous, active low; clears the phase, the output valid flag and the
//   window registers to their defaults. Local memory contents are undefined.
module dual_port_memory_bus_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  dpmbc_pkg::dpmbc_in_t            s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output dpmbc_pkg::dpmbc_out_t           m_result,
    input  logic                            cfg_write,
    input  logic [dpmbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dpmbc_pkg::DATA_W-1:0]    cfg_data
);
    import dpmbc_pkg::*;

    logic           accept;
    dpmbc_out_t     result;
    dpmbc_mem_req_t mem_req;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] read_reg;
    logic [DATA_W-1:0] rd_word;
    logic           rd_fresh_reg;
    logic           m_valid_reg;
    dpmbc_out_t     m_result_reg;

    assign s_ready = aresetn & (~m_valid_reg | m_ready);
    assign accept  = s_valid & s_ready;

    dpmbc_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .item      (s_item),
        .rd_word   (rd_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .mem_req   (mem_req)
    );

    dpmbc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.index),
        .wr_data (mem_req.wdata),
        .wr_mask (mem_req.wmask),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.index),
        .rd_data (ram_rdata)
    );

    // forward the RAM output on the cycle right after the read,
    // later requests use the captured copy
    assign rd_word = rd_fresh_reg ? ram_rdata : read_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_fresh_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_fresh_reg <= mem_req.rd_en;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_fresh_reg) begin
            read_reg <= ram_rdata;
        end
        if (accept) begin
            m_result_reg <= result;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    a_fresh_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_fresh_reg |-> $past(mem_req.rd_en))
        else $error("read forward flag without a read");

    a_no_rw_same_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("memory read and write in one cycle");

    a_accept_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted request produced no result");

endmodule

// ----- dv/dual_port_memory_bus_controller_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_port_memory_bus_controller_tb
// Runs bus ticks through the controller and checks every response against a
// cycle-accurate predictor: local word memory, instruction fetch priority,
// address window decode and wishbone forwarding, under several window
// settings and with random stalls on both channels.
// ----------------------------------------------------------------------------
module dual_port_memory_bus_controller_tb;
    import dpmbc_pkg::*;

    localparam int LONG_HOLD = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(3);
    localparam dpmbc_in_t QUIET = '0;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LRD1, ST_LRD2, ST_LWR1, ST_LWR2, ST_FETCH1, ST_FETCH2,
        ST_BWR1, ST_BWR2, ST_BWR3, ST_BRD1, ST_BRD2
    } ctl_state_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    dpmbc_in_t            s_item    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    dpmbc_out_t           m_result;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    // predictor state
    ctl_state_t        ctl_state  = ST_IDLE;
    logic [DATA_W-1:0] win_start  = START_ADDRESS_RST;
    logic [DATA_W-1:0] win_limit  = WINDOW_LIMIT_RST;
    logic [DATA_W-1:0] fetched_word;
    logic [DATA_W-1:0] mirror_mem   [MEM_WORDS];
    logic [BE_W-1:0]   mirror_valid [MEM_WORDS];
    int                full_words[$];
    dpmbc_out_t        responses_due[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_requests = 0;
    int stall_served   = 0;
    int stall_left     = 0;

    dual_port_memory_bus_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic in_window(logic [DATA_W-1:0] addr);
        logic [DATA_W-1:0] off;
        off = addr - win_start;
        return off <= win_limit;
    endfunction

    function automatic logic [MEM_IDX_W-1:0] word_index(logic [DATA_W-1:0] addr);
        return addr[MEM_IDX_W+1:2];
    endfunction

    // random upper and low bits, word index fixed
    function automatic logic [DATA_W-1:0] addr_for_word(int idx);
        logic [DATA_W-1:0] a;
        a = $urandom();
        a[MEM_IDX_W+1:2] = idx[MEM_IDX_W-1:0];
        return a;
    endfunction

    // one tick of the controller: returns the bus outputs, advances the state
    function automatic dpmbc_out_t next_bus_response(dpmbc_in_t t);
        dpmbc_out_t           r;
        logic [MEM_IDX_W-1:0] idx;
        r = '0;
        case (ctl_state)
            ST_IDLE: begin
                if (t.instr_strobe)
                    ctl_state = ST_FETCH1;
                else if (t.data_strobe) begin
                    if (in_window(t.data_address))
                        ctl_state = t.data_write ? ST_LWR1 : ST_LRD1;
                    else
                        ctl_state = t.data_write ? ST_BWR1 : ST_BRD1;
                end
            end
            ST_LRD1: begin
                fetched_word = mirror_mem[word_index(t.data_address)];
                ctl_state = ST_LRD2;
            end
            ST_LRD2: begin
                r.data_read_value = fetched_word;
                r.data_ack = 1'b1;
                ctl_state = ST_IDLE;
            end
            ST_LWR1: begin
                idx = word_index(t.data_address);
                for (int k = 0; k < BE_W; k++)
                    if (t.byte_enables[k])
                        mirror_mem[idx][8*k +: 8] = t.data_write_value[8*k +: 8];
                if (mirror_valid[idx] != '1 && (mirror_valid[idx] | t.byte_enables) == '1)
                    full_words.push_back(int'(idx));
                mirror_valid[idx] |= t.byte_enables;
                ctl_state = ST_LWR2;
            end
            ST_LWR2: begin
                r.data_ack = 1'b1;
                ctl_state = ST_IDLE;
            end
            ST_FETCH1: begin
                fetched_word = mirror_mem[word_index(t.instr_address)];
                ctl_state = ST_FETCH2;
            end
            ST_FETCH2: begin
                r.instr_read_value = fetched_word;
                r.instr_ack = 1'b1;
                ctl_state = ST_IDLE;
            end
            ST_BWR1, ST_BWR2, ST_BWR3: begin
                r.bus_address = t.data_address;
                r.bus_write_value = t.data_write_value;
                r.bus_cycle_strobe = 1'b1;
                r.bus_write_enable = 1'b1;
                r.bus_select = BUS_SEL_ALL;
                // first tick ignores the slave ack; core ack follows the bus ack
                if (ctl_state == ST_BWR1)
                    ctl_state = ST_BWR2;
                else if (ctl_state == ST_BWR2) begin
                    if (t.bus_ack_in)
                        ctl_state = ST_BWR3;
                end else begin
                    r.data_ack = 1'b1;
                    ctl_state = ST_IDLE;
                end
            end
            ST_BRD1: begin
                r.bus_address = t.data_address;
                r.bus_cycle_strobe = 1'b1;
                r.bus_select = BUS_SEL_ALL;
                if (t.bus_ack_in)
                    ctl_state = ST_BRD2;
            end
            ST_BRD2: begin
                r.bus_address = t.data_address;
                r.bus_cycle_strobe = 1'b1;
                r.bus_select = BUS_SEL_ALL;
                r.data_read_value = t.bus_read_value;
                r.data_ack = 1'b1;
                ctl_state = ST_IDLE;
            end
            default: ctl_state = ST_IDLE;
        endcase
        return r;
    endfunction

    function automatic dpmbc_in_t bus_tick(logic istb, logic [DATA_W-1:0] iadr,
                                           logic dstb, logic dwe,
                                           logic [DATA_W-1:0] dadr,
                                           logic [DATA_W-1:0] wdat,
                                           logic [BE_W-1:0] be, logic ack,
                                           logic [DATA_W-1:0] rdat);
        dpmbc_in_t t;
        t.instr_strobe = istb;
        t.instr_address = iadr;
        t.data_strobe = dstb;
        t.data_write = dwe;
        t.data_address = dadr;
        t.data_write_value = wdat;
        t.byte_enables = be;
        t.bus_ack_in = ack;
        t.bus_read_value = rdat;
        return t;
    endfunction

    // random tick shaped by the predicted state: mostly whole transactions,
    // reads only ever land on fully written words
    function automatic dpmbc_in_t make_tick();
        dpmbc_in_t         t;
        int                pick;
        logic [DATA_W-1:0] off;
        t = bus_tick(1'($urandom_range(1, 0)), $urandom(), 1'($urandom_range(1, 0)),
                     1'($urandom_range(1, 0)), $urandom(), $urandom(),
                     4'($urandom_range(15, 0)), 1'($urandom_range(1, 0)), $urandom());
        pick = $urandom_range(99, 0);
        case (ctl_state)
            ST_IDLE: begin
                if (pick >= 15) begin
                    // 15..34 fetch, 35..54 local read, 55..74 local write,
                    // 75..87 bus write, 88..99 bus read
                    t.instr_strobe = (pick < 35);
                    t.data_strobe = 1'b1;
                    t.data_write = (pick >= 55 && pick < 88);
                    if (pick < 75 || win_limit == '1) begin
                        case ($urandom_range(3, 0))
                            0: off = '0;
                            1: off = win_limit;
                            default: off = $urandom_range(win_limit, 0);
                        endcase
                    end else begin
                        case ($urandom_range(3, 0))
                            0: off = win_limit + 1;
                            1: off = '1;
                            default: off = win_limit + 1 + $urandom_range(~win_limit - 1, 0);
                        endcase
                    end
                    t.data_address = win_start + off;
                end
                if (full_words.size() == 0) begin
                    t.instr_strobe = 1'b0;
                    if (t.data_strobe && !t.data_write && in_window(t.data_address))
                        t.data_write = 1'b1;
                end
            end
            ST_LRD1:
                t.data_address = addr_for_word(full_words[$urandom_range(full_words.size() - 1, 0)]);
            ST_FETCH1:
                t.instr_address = addr_for_word(full_words[$urandom_range(full_words.size() - 1, 0)]);
            ST_LWR1: begin
                case ($urandom_range(9, 0))
                    0, 1, 2, 3, 4, 5, 6: t.data_address = addr_for_word($urandom_range(31, 0));
                    7: t.data_address = addr_for_word(MEM_WORDS - 1 - $urandom_range(3, 0));
                    default: t.data_address = addr_for_word($urandom_range(MEM_WORDS - 1, 0));
                endcase
                if (pick < 60)
                    t.byte_enables = '1;
            end
            ST_BWR2, ST_BRD1:
                t.bus_ack_in = (pick < 40);
            default: ;
        endcase
        return t;
    endfunction

    task automatic log_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        if (mismatch_count < 40)
            $display("%0t: mismatch %s: got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_tick(dpmbc_in_t req);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= req;
        do @(posedge aclk); while (!s_ready);
        responses_due.push_back(next_bus_response(req));
    endtask

    task automatic settle_idle();
        dpmbc_in_t t;
        while (ctl_state != ST_IDLE) begin
            t = make_tick();
            t.instr_strobe = 1'b0;
            t.data_strobe = 1'b0;
            t.bus_ack_in = 1'b1;
            send_tick(t);
        end
        s_valid <= 1'b0;
        while (responses_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_window_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_WIN_BASE)
            win_start = value;
        else if (idx == CFG_WINDOW_LIMIT)
            win_limit = value;
        @(posedge aclk);
        cfg_write <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_window(logic [DATA_W-1:0] start, logic [DATA_W-1:0] limit);
        settle_idle();
        write_window_reg(CFG_WIN_BASE, start);
        write_window_reg(CFG_WINDOW_LIMIT, limit);
    endtask

    // default window: start 0x10000000, limit 0x101FFFFF
    task automatic test_directed_cases();
        write_window_reg(CFG_UNUSED_IDX, '1);
        // local write at offset zero, full word of ones into word 0
        send_tick(bus_tick(0, 0, 1, 1, 32'h1000_0000, 0, 0, 0, 0));
        send_tick(bus_tick(0, 0, 0, 0, 32'h0000_0000, '1, 4'hF, 0, 0));
        send_tick(QUIET);
        // offset equal to the limit is still local; top word gets zero
        send_tick(bus_tick(0, 0, 1, 1, 32'h201F_FFFF, 0, 0, 0, 0));
        send_tick(bus_tick(0, 0, 0, 0, 32'hFFFF_FFFF, 0, 4'hF, 1, 0));
        send_tick(QUIET);
        // partial write into word 0
        send_tick(bus_tick(0, 0, 1, 1, 32'h1000_0004, 0, 0, 0, 0));
        send_tick(bus_tick(0, 0, 0, 0, 32'h0000_0002, 0, 4'b0101, 0, 0));
        send_tick(QUIET);
        // no byte enables: nothing stored, still acknowledged
        send_tick(bus_tick(0, 0, 1, 1, 32'h1000_0004, 0, 0, 0, 0));
        send_tick(bus_tick(0, 0, 0, 0, 32'h0000_0004, 32'hA5A5_A5A5, 4'h0, 0, 0));
        send_tick(QUIET);
        // both strobes: fetch wins, reads the top word
        send_tick(bus_tick(1, 0, 1, 0, 32'h1000_0000, 0, 0, 0, 0));
        send_tick(bus_tick(0, 32'hFFFF_FFFC, 0, 0, 0, 0, 0, 0, 0));
        send_tick(QUIET);
        // local read, index wraps modulo the memory size
        send_tick(bus_tick(0, 0, 1, 0, 32'h1000_0008, 0, 0, 0, 0));
        send_tick(bus_tick(0, 0, 0, 0, 32'h8000_0001, 0, 0, 0, 0));
        send_tick(QUIET);
        // one past the window goes out on the bus: read waits for ack
        send_tick(bus_tick(0, 0, 1, 0, 32'h2020_0000, 0, 0, 0, 0));
        send_tick(bus_tick(0, 0, 0, 0, 32'h2020_0000, 0, 0, 0, '1));
        send_tick(bus_tick(0, 0, 0, 0, 32'h2020_0000, 0, 0, 1, 0));
        send_tick(bus_tick(0, 0, 0, 0, 32'h2020_0000, 0, 0, 0, '1));
        // address below start wraps far outside: bus write
        send_tick(bus_tick(0, 0, 1, 1, 32'h0000_0000, '1, 0, 0, 0));
        send_tick(bus_tick(0, 0, 0, 0, 32'h0000_0000, '1, 0, 1, 0));
        send_tick(bus_tick(0, 0, 0, 0, 32'h0000_0000, '1, 0, 0, 0));
        send_tick(bus_tick(0, 0, 0, 0, 32'h0000_0000, '1, 0, 1, 0));
        send_tick(bus_tick(0, 0, 0, 0, 32'h0000_0000, '1, 0, 0, 0));
        settle_idle();
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_tick(make_tick());
    endtask

    // receiver holds off while requests keep coming
    task automatic test_output_backpressure();
        stall_requests++;
        repeat (80) send_tick(make_tick());
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_served != stall_requests) begin
            stall_served <= stall_requests;
            stall_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        dpmbc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (responses_due.size() == 0) begin
                log_mismatch("response with none due", m_result.data_ack, 0);
            end else begin
                want = responses_due.pop_front();
                if (m_result.instr_ack !== want.instr_ack)
                    log_mismatch("instr_ack", m_result.instr_ack, want.instr_ack);
                if (m_result.instr_read_value !== want.instr_read_value)
                    log_mismatch("instr_read_value", m_result.instr_read_value,
                                 want.instr_read_value);
                if (m_result.data_ack !== want.data_ack)
                    log_mismatch("data_ack", m_result.data_ack, want.data_ack);
                if (m_result.data_read_value !== want.data_read_value)
                    log_mismatch("data_read_value", m_result.data_read_value,
                                 want.data_read_value);
                if (m_result.bus_address !== want.bus_address)
                    log_mismatch("bus_address", m_result.bus_address, want.bus_address);
                if (m_result.bus_write_value !== want.bus_write_value)
                    log_mismatch("bus_write_value", m_result.bus_write_value,
                                 want.bus_write_value);
                if (m_result.bus_cycle_strobe !== want.bus_cycle_strobe)
                    log_mismatch("bus_cycle_strobe", m_result.bus_cycle_strobe,
                                 want.bus_cycle_strobe);
                if (m_result.bus_write_enable !== want.bus_write_enable)
                    log_mismatch("bus_write_enable", m_result.bus_write_enable,
                                 want.bus_write_enable);
                if (m_result.bus_select !== want.bus_select)
                    log_mismatch("bus_select", m_result.bus_select, want.bus_select);
            end
        end
    end

    initial begin
        for (int i = 0; i < MEM_WORDS; i++)
            mirror_valid[i] = '0;
        send_idle_pct = 32;
        recv_idle_pct = 45;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_traffic(200);

        apply_window('0, '1);
        test_random_traffic(200);

        send_idle_pct = 45;
        recv_idle_pct = 32;
        apply_window($urandom(), '0);
        test_random_traffic(200);
        test_output_backpressure();

        apply_window('1, 32'h7FFF_FFFF);
        test_random_traffic(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_window(START_ADDRESS_RST, 32'h0003_FFFF);
        test_random_traffic(150);

        settle_idle();
        if (responses_due.size() != 0)
            log_mismatch("responses never returned", responses_due.size(), 0);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
